// File: design/cbs_pkg.sv
// Shared constants, types and helpers for the centroid bounding sphere unit.
package cbs_pkg;

  localparam int MAX_POINTS  = 1024;
  localparam int COORD_BITS  = 24;
  localparam int ADDR_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SUM_W       = COORD_BITS + CNT_W;
  localparam int IT_W        = $clog2(SUM_W + 1);
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int WORD_W      = 3 * COORD_BITS;
  localparam int OUT_COORD_W = 24;
  localparam int OUT_RAD_W   = 50;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } cbs_state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } cbs_axis_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } cbs_div_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [COORD_BITS-1:0] quotient;
  } cbs_div_rsp_t;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                     input logic signed [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    abs_diff = d[COORD_BITS] ? COORD_BITS'(-d) : d[COORD_BITS-1:0];
  endfunction

endpackage

// File: design/centroid_bounding_sphere_unit.sv
// Top level of the centroid bounding sphere unit: point store, sums, divider and scan.
// Loading takes one point per cycle; start is taken whenever busy is low.
// After the request marked last, the serial divider forms the three centre coordinates in turn,
// then the point memory is scanned one read per cycle and the distance pipeline drains;
// busy stays high until the result strobe.
// Synchronous reset clears control, sums and count; the point memory is not cleared.
module centroid_bounding_sphere_unit import cbs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [23:0]           in_point_x,
  input  logic [23:0]           in_point_y,
  input  logic [23:0]           in_point_z,
  input  logic                  in_last_point,
  output logic                  out_valid,
  output logic [OUT_COORD_W-1:0] out_center_x,
  output logic [OUT_COORD_W-1:0] out_center_y,
  output logic [OUT_COORD_W-1:0] out_center_z,
  output logic [OUT_RAD_W-1:0]  out_radius_squared,
  output logic                  out_status
);

  logic [WORD_W-1:0] mem [MAX_POINTS];

  cbs_state_t state_r, state_nxt;
  cbs_axis_t  axis_r, axis_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             scan_r, scan_nxt;
  logic signed [SUM_W-1:0]      sum_x_r, sum_x_nxt;
  logic signed [SUM_W-1:0]      sum_y_r, sum_y_nxt;
  logic signed [SUM_W-1:0]      sum_z_r, sum_z_nxt;
  logic signed [COORD_BITS-1:0] center_x_r, center_x_nxt;
  logic signed [COORD_BITS-1:0] center_y_r, center_y_nxt;
  logic signed [COORD_BITS-1:0] center_z_r, center_z_nxt;
  logic [OUT_RAD_W-1:0]         best_r, best_nxt;
  logic                         overflow_r, overflow_nxt;

  logic signed [COORD_BITS-1:0] px, py, pz;
  logic              mem_we;
  logic              rd_en;
  logic [WORD_W-1:0] rd_data_r;
  logic              v1_r, v2_r, v3_r;
  logic [COORD_BITS-1:0] ad_x_r, ad_y_r, ad_z_r;
  logic [SQ_W-1:0]   sq_x_r, sq_y_r, sq_z_r;
  logic [OUT_RAD_W-1:0] sq_dist;
  logic              pipe_empty;

  cbs_div_req_t div_req;
  cbs_div_rsp_t div_rsp;

  cbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign px = $signed(in_point_x[COORD_BITS-1:0]);
  assign py = $signed(in_point_y[COORD_BITS-1:0]);
  assign pz = $signed(in_point_z[COORD_BITS-1:0]);

  assign sq_dist = OUT_RAD_W'(sq_x_r) + OUT_RAD_W'(sq_y_r) + OUT_RAD_W'(sq_z_r);
  assign pipe_empty = !(v1_r || v2_r || v3_r);

  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    sum_z_nxt    = sum_z_r;
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    center_z_nxt = center_z_r;
    overflow_nxt = overflow_r;
    best_nxt     = best_r;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    busy         = 1'b1;
    out_valid    = 1'b0;
    div_req      = '0;

    if (v3_r && (sq_dist > best_r)) begin
      best_nxt = sq_dist;
    end

    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (count_r < CNT_W'(MAX_POINTS)) begin
            mem_we    = 1'b1;
            sum_x_nxt = sum_x_r + SUM_W'(px);
            sum_y_nxt = sum_y_r + SUM_W'(py);
            sum_z_nxt = sum_z_r + SUM_W'(pz);
            count_nxt = count_r + CNT_W'(1);
          end else begin
            overflow_nxt = 1'b1;
          end
          if (in_last_point) begin
            axis_nxt  = AXIS_X;
            state_nxt = ST_DIV_ISSUE;
          end
        end
      end
      ST_DIV_ISSUE: begin
        div_req.valid   = 1'b1;
        div_req.divisor = count_r;
        case (axis_r)
          AXIS_X:  div_req.dividend = sum_x_r;
          AXIS_Y:  div_req.dividend = sum_y_r;
          AXIS_Z:  div_req.dividend = sum_z_r;
          default: div_req.dividend = '0;
        endcase
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (axis_r)
            AXIS_X:  center_x_nxt = (count_r == '0) ? '0 : div_rsp.quotient;
            AXIS_Y:  center_y_nxt = (count_r == '0) ? '0 : div_rsp.quotient;
            default: center_z_nxt = (count_r == '0) ? '0 : div_rsp.quotient;
          endcase
          if (axis_r == AXIS_Z) begin
            scan_nxt  = '0;
            state_nxt = (count_r == '0) ? ST_DRAIN : ST_SCAN;
          end else begin
            axis_nxt  = (axis_r == AXIS_X) ? AXIS_Y : AXIS_Z;
            state_nxt = ST_DIV_ISSUE;
          end
        end
      end
      ST_SCAN: begin
        rd_en    = 1'b1;
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == CNT_W'(count_r - CNT_W'(1))) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid    = 1'b1;
        sum_x_nxt    = '0;
        sum_y_nxt    = '0;
        sum_z_nxt    = '0;
        count_nxt    = '0;
        overflow_nxt = 1'b0;
        best_nxt     = '0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      axis_r     <= AXIS_X;
      count_r    <= '0;
      scan_r     <= '0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      sum_z_r    <= '0;
      overflow_r <= 1'b0;
      best_r     <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      axis_r     <= axis_nxt;
      count_r    <= count_nxt;
      scan_r     <= scan_nxt;
      sum_x_r    <= sum_x_nxt;
      sum_y_r    <= sum_y_nxt;
      sum_z_r    <= sum_z_nxt;
      overflow_r <= overflow_nxt;
      best_r     <= best_nxt;
      v1_r       <= rd_en;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    center_x_r <= center_x_nxt;
    center_y_r <= center_y_nxt;
    center_z_r <= center_z_nxt;
    ad_x_r <= abs_diff(rd_data_r[COORD_BITS-1:0], center_x_r);
    ad_y_r <= abs_diff(rd_data_r[2*COORD_BITS-1:COORD_BITS], center_y_r);
    ad_z_r <= abs_diff(rd_data_r[3*COORD_BITS-1:2*COORD_BITS], center_z_r);
    sq_x_r <= ad_x_r * ad_x_r;
    sq_y_r <= ad_y_r * ad_y_r;
    sq_z_r <= ad_z_r * ad_z_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= {pz, py, px};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[scan_r[ADDR_W-1:0]];
    end
  end

  assign out_center_x       = OUT_COORD_W'(center_x_r);
  assign out_center_y       = OUT_COORD_W'(center_y_r);
  assign out_center_z       = OUT_COORD_W'(center_z_r);
  assign out_radius_squared = best_r;
  assign out_status         = overflow_r;

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("Result strobe while not busy.");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("Point count exceeds store depth.");

  a_overflow_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (count_r == CNT_W'(MAX_POINTS))) |=> overflow_r)
    else $error("Dropped point did not set the overflow flag.");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!v1_r && !v2_r && !v3_r))
    else $error("Result issued before the distance pipeline drained.");

endmodule

// File: design/cbs_div.sv
// Iterative restoring divider: signed sum by unsigned count, truncating toward zero.
module cbs_div import cbs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cbs_div_req_t req,
  output cbs_div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [IT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic              neg_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [SUM_W-1:0]  mag;
  logic [COORD_BITS-1:0] q_mag;

  assign mag   = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : req.dividend;
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.valid && busy_r && (cnt_r == IT_W'(1));
      if (req.valid) begin
        busy_r <= 1'b1;
        cnt_r  <= IT_W'(SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - IT_W'(1);
        if (cnt_r == IT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= req.divisor;
      neg_r <= req.dividend[SUM_W-1];
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign q_mag        = quo_r[COORD_BITS-1:0];
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? COORD_BITS'(-q_mag) : q_mag;

endmodule

// File: test/tb_centroid_bounding_sphere_unit.sv
// Self-checking testbench for the centroid bounding sphere unit with its own sphere predictor.
module tb_centroid_bounding_sphere_unit;
  import cbs_pkg::*;

  typedef struct {
    logic [OUT_COORD_W-1:0] cx;
    logic [OUT_COORD_W-1:0] cy;
    logic [OUT_COORD_W-1:0] cz;
    logic [OUT_RAD_W-1:0]   r2;
    logic                   status;
  } sphere_t;

  localparam logic [23:0] COORD_MAX  = 24'h7FFFFF;
  localparam logic [23:0] COORD_MIN  = 24'h800000;
  localparam logic [23:0] COORD_ZERO = 24'h000000;
  localparam logic [23:0] COORD_NEG1 = 24'hFFFFFF;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [23:0]            in_point_x = '0;
  logic [23:0]            in_point_y = '0;
  logic [23:0]            in_point_z = '0;
  logic                   in_last_point = 1'b0;
  logic                   out_valid;
  logic [OUT_COORD_W-1:0] out_center_x;
  logic [OUT_COORD_W-1:0] out_center_y;
  logic [OUT_COORD_W-1:0] out_center_z;
  logic [OUT_RAD_W-1:0]   out_radius_squared;
  logic                   out_status;

  logic signed [COORD_BITS-1:0] stored_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] stored_y [MAX_POINTS];
  logic signed [COORD_BITS-1:0] stored_z [MAX_POINTS];
  longint                       acc_x;
  longint                       acc_y;
  longint                       acc_z;
  int unsigned                  stored_count;
  bit                           store_spilled;

  sphere_t     pending_spheres [$];
  sphere_t     oldest_sphere;
  int unsigned error_count;
  int unsigned points_sent;
  int unsigned spheres_checked;
  int unsigned spilled_sets;

  always #10 clk = ~clk;

  centroid_bounding_sphere_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_point_x         (in_point_x),
    .in_point_y         (in_point_y),
    .in_point_z         (in_point_z),
    .in_last_point      (in_last_point),
    .out_valid          (out_valid),
    .out_center_x       (out_center_x),
    .out_center_y       (out_center_y),
    .out_center_z       (out_center_z),
    .out_radius_squared (out_radius_squared),
    .out_status         (out_status)
  );

  function automatic longint unsigned axis_sq(input longint a, input longint b);
    longint d;
    d = a - b;
    return longint'(d * d);
  endfunction

  function automatic void predict_sphere(input logic [23:0] x, input logic [23:0] y,
                                         input logic [23:0] z, input logic is_last);
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    longint                       cx;
    longint                       cy;
    longint                       cz;
    longint unsigned              pt_dist;
    longint unsigned              best;
    sphere_t                      s;
    px = x[COORD_BITS-1:0];
    py = y[COORD_BITS-1:0];
    pz = z[COORD_BITS-1:0];
    if (stored_count < MAX_POINTS) begin
      stored_x[stored_count] = px;
      stored_y[stored_count] = py;
      stored_z[stored_count] = pz;
      acc_x += px;
      acc_y += py;
      acc_z += pz;
      stored_count++;
    end else begin
      store_spilled = 1'b1;
    end
    if (!is_last) return;
    cx = 0;
    cy = 0;
    cz = 0;
    if (stored_count != 0) begin
      cx = acc_x / longint'(stored_count);
      cy = acc_y / longint'(stored_count);
      cz = acc_z / longint'(stored_count);
    end
    best = 0;
    for (int unsigned i = 0; i < stored_count; i++) begin
      pt_dist = axis_sq(stored_x[i], cx) + axis_sq(stored_y[i], cy) + axis_sq(stored_z[i], cz);
      if (pt_dist > best) best = pt_dist;
    end
    s.cx = cx[OUT_COORD_W-1:0];
    s.cy = cy[OUT_COORD_W-1:0];
    s.cz = cz[OUT_COORD_W-1:0];
    s.r2 = best[OUT_RAD_W-1:0];
    s.status = store_spilled;
    pending_spheres = {pending_spheres, s};
    if (store_spilled) spilled_sets++;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    stored_count = 0;
    store_spilled = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_spheres.size() == 0) begin
        $error("result with no request pending");
        error_count++;
      end else begin
        oldest_sphere = pending_spheres.pop_front();
        spheres_checked++;
        if (out_center_x !== oldest_sphere.cx) begin
          $error("center_x: expected %0d, actual %0d",
                 $signed(oldest_sphere.cx), $signed(out_center_x));
          error_count++;
        end
        if (out_center_y !== oldest_sphere.cy) begin
          $error("center_y: expected %0d, actual %0d",
                 $signed(oldest_sphere.cy), $signed(out_center_y));
          error_count++;
        end
        if (out_center_z !== oldest_sphere.cz) begin
          $error("center_z: expected %0d, actual %0d",
                 $signed(oldest_sphere.cz), $signed(out_center_z));
          error_count++;
        end
        if (out_radius_squared !== oldest_sphere.r2) begin
          $error("radius_squared: expected %0d, actual %0d",
                 oldest_sphere.r2, out_radius_squared);
          error_count++;
        end
        if (out_status !== oldest_sphere.status) begin
          $error("status: expected %0d, actual %0d", oldest_sphere.status, out_status);
          error_count++;
        end
      end
    end
  end

  task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                            input logic [23:0] z, input logic is_last);
    start <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    in_last_point <= is_last;
    do @(posedge clk); while (busy);
    predict_sphere(x, y, z, is_last);
    points_sent++;
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      in_point_x <= 24'($urandom);
      in_point_y <= 24'($urandom);
      in_point_z <= 24'($urandom);
      in_last_point <= 1'($urandom);
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_all_spheres();
    start <= 1'b0;
    @(posedge clk);
    while (pending_spheres.size() != 0) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_coord(input logic [23:0] base);
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return COORD_ZERO;
      3, 4: return base + 24'($urandom_range(0, 511)) - 24'd256;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_set(input int unsigned n, input bit allow_idle);
    logic [23:0] bx;
    logic [23:0] by;
    logic [23:0] bz;
    bx = 24'($urandom);
    by = 24'($urandom);
    bz = 24'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      send_point(pick_coord(bx), pick_coord(by), pick_coord(bz), i == n - 1);
      maybe_idle(allow_idle);
    end
  endtask

  task automatic test_single_points();
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_point(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1);
    maybe_idle(1'b1);
    send_point(COORD_NEG1, COORD_MAX, COORD_MIN, 1'b1);
    send_point(24'h001000, 24'hFFF000, 24'h555555, 1'b1);
  endtask

  task automatic test_extreme_sets();
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    maybe_idle(1'b1);
    send_point(24'hFFFFFD, 24'h000003, COORD_ZERO, 1'b0);
    send_point(COORD_ZERO, COORD_ZERO, 24'hFFFFFF, 1'b1);
    send_point(COORD_NEG1, 24'h000005, 24'h000002, 1'b0);
    send_point(COORD_NEG1, COORD_ZERO, 24'hFFFFFE, 1'b0);
    send_point(COORD_ZERO, COORD_ZERO, 24'hFFFFFF, 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_ZERO, COORD_ZERO, COORD_ZERO, 1'b1);
  endtask

  task automatic test_store_full();
    wait_all_spheres();
    send_set(MAX_POINTS + 1, 1'b1);
    wait_all_spheres();
  endtask

  task automatic test_random_sets();
    int unsigned target;
    int unsigned sets;
    target = points_sent + 120;
    sets = 0;
    while (points_sent < target) begin
      if ($urandom_range(0, 9) == 0) send_set($urandom_range(13, 64), 1'b1);
      else send_set($urandom_range(1, 12), 1'b1);
      sets++;
      if (sets % 12 == 0) wait_all_spheres();
    end
  endtask

  task automatic test_back_to_back();
    for (int k = 0; k < 10; k++) send_set($urandom_range(1, 10), 1'b0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_points();
    test_extreme_sets();
    test_store_full();
    test_random_sets();
    test_back_to_back();
    wait_all_spheres();
    repeat (20) @(posedge clk);
    $display("Sent %0d points and checked %0d spheres, including sets from one point",
             points_sent, spheres_checked);
    $display("up to past the full store; %0d sets overflowed the store.", spilled_sets);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: filelist.f
design/cbs_pkg.sv
design/cbs_div.sv
design/centroid_bounding_sphere_unit.sv
test/tb_centroid_bounding_sphere_unit.sv
